// File: src/pfc_pkg.sv
// ----------------------------------------------------------------------------
// Playfair cipher engine package
// Shared beat types, action codes, controller command and status structs and
// the small letter and square-geometry helpers used by the datapath.
// ----------------------------------------------------------------------------
package pfc_pkg;

    // action codes of an input beat
    localparam logic [1:0] ACT_KEY    = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_TEXT   = 2'd2;
    localparam logic [1:0] ACT_END    = 2'd3;

    // letter indexes, 0 is A
    localparam logic [4:0] LETTER_I = 5'd8;
    localparam logic [4:0] LETTER_J = 5'd9;
    localparam logic [4:0] LETTER_X = 5'd23;
    localparam logic [4:0] LETTER_Z = 5'd25;

    localparam logic [7:0] ASCII_UA = 8'd65;   // 'A'
    localparam logic [7:0] ASCII_UZ = 8'd90;   // 'Z'
    localparam logic [7:0] ASCII_LA = 8'd97;   // 'a'
    localparam logic [7:0] ASCII_LZ = 8'd122;  // 'z'
    localparam logic [7:0] CASE_GAP = 8'd32;

    localparam logic [2:0] SIDE_LAST = 3'd4;   // last row / column of the square
    localparam logic [4:0] CELLS     = 5'd25;

    // held letter update
    localparam logic [1:0] HOLD_KEEP  = 2'd0;
    localparam logic [1:0] HOLD_LOAD  = 2'd1;
    localparam logic [1:0] HOLD_CLEAR = 2'd2;

    // prior second letter update
    localparam logic [1:0] PRI_KEEP   = 2'd0;
    localparam logic [1:0] PRI_LOAD_C = 2'd1;
    localparam logic [1:0] PRI_LOAD_X = 2'd2;
    localparam logic [1:0] PRI_CLEAR  = 2'd3;

    // operands of the first pair: held/text, held/X, X/text
    localparam logic [1:0] PAIR_HC = 2'd0;
    localparam logic [1:0] PAIR_HX = 2'd1;
    localparam logic [1:0] PAIR_XC = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
    } t_in_item;

    typedef struct packed {
        logic [6:0] letter;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic       ok;
        logic [4:0] idx;
    } t_key_letter;

    typedef struct packed {
        logic [1:0] act;
        logic       key_ok;
        logic       full;
        logic       held_v;
        logic       prior_v;
        logic       c_eq_held;
        logic       c_eq_prior;
        logic       c_is_x;
        logic       decrypt;
        logic       walk_last;
        logic       out_free;
    } t_status;

    typedef struct packed {
        logic       load_in;
        logic       place_key;
        logic       walk_start;
        logic       walk_step;
        logic [1:0] held_op;
        logic [1:0] prior_op;
        logic       latch_ops;
        logic [1:0] pair_kind;
        logic       lookup;
        logic       second;
        logic       square;
        logic       emit_a;
        logic       emit_b;
        logic       last_b;
    } t_cmd;

    function automatic logic [7:0] fold_upper(input logic [7:0] ch);
        if (ch >= ASCII_LA && ch <= ASCII_LZ) begin
            return ch - CASE_GAP;
        end
        return ch;
    endfunction

    // key byte: a letter other than J, folded
    function automatic t_key_letter key_letter(input logic [7:0] ch);
        t_key_letter r;
        logic [7:0]  u;
        u = fold_upper(ch);
        r.idx = 5'(u - ASCII_UA);
        r.ok  = (u >= ASCII_UA) && (u <= ASCII_UZ) && (r.idx != LETTER_J);
        return r;
    endfunction

    // text byte: anything that is not a letter, and J, maps to I
    function automatic logic [4:0] text_letter(input logic [7:0] ch);
        t_key_letter k;
        k = key_letter(ch);
        return k.ok ? k.idx : LETTER_I;
    endfunction

    function automatic logic [2:0] row_of(input logic [4:0] pos);
        if (pos >= 5'd20) return 3'd4;
        if (pos >= 5'd15) return 3'd3;
        if (pos >= 5'd10) return 3'd2;
        if (pos >= 5'd5)  return 3'd1;
        return 3'd0;
    endfunction

    function automatic logic [4:0] cell_at(input logic [2:0] row, input logic [2:0] col);
        return {row, 2'b00} + 5'(row) + 5'(col);
    endfunction

    function automatic logic [2:0] col_of(input logic [4:0] pos);
        return 3'(pos - cell_at(row_of(pos), 3'd0));
    endfunction

    // one place on round the square, backwards when decrypting
    function automatic logic [2:0] step5(input logic [2:0] v, input logic dec);
        if (dec) begin
            return (v == 3'd0) ? SIDE_LAST : v - 3'd1;
        end
        return (v == SIDE_LAST) ? 3'd0 : v + 3'd1;
    endfunction

endpackage

// File: src/playfair_cipher_engine.sv
// ----------------------------------------------------------------------------
// Playfair cipher engine
// Builds a 5x5 key square from key beats and encrypts or decrypts text
// beats pair by pair, one input beat at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one action
//   and one byte per beat: key byte, key finish, text byte or text end.
//   Output channel (o_out_valid / i_out_ready / o_out_item) carries one
//   upper-case letter per beat; last_of_run marks the final letter caused by
//   an input beat. A text beat gives 0, 2 or 4 output beats.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_data) sets decrypt
//   mode and is always ready; the user writes it only while the engine is
//   idle, which the block does not enforce.
// A key byte, or a text beat that gives no letters, is only decoded. Key
// finish starts the alphabet walk over A to Z, placing each letter not yet
// used other than J. A text beat with pairs gives, per pair, a lookup, a
// square read and two output stages; a second pair repeats them. Each
// pair's letter-place read and square read are both registered.
// Reset clears the square fill, used letters, pairing state and mode; the
// stores need no clearing since text is refused until the square is full.
// A stalled receiver holds the output register and the controller waits in
// its output stage; no letter is lost or repeated.
// ----------------------------------------------------------------------------
module playfair_cipher_engine (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  pfc_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pfc_pkg::t_out_item  o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    pfc_pkg::t_cmd    cmd;
    pfc_pkg::t_status status;

    // mode register takes a write every cycle
    assign o_cfg_ready = 1'b1;

    pfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pfc_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

// File: src/pfc_ctrl.sv
// ----------------------------------------------------------------------------
// Playfair controller
// Sequences one input beat at a time: decode, alphabet walk, pair lookup,
// square read and the two output beats of each pair.
// ----------------------------------------------------------------------------
module pfc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  pfc_pkg::t_status i_status,
    output pfc_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_WALK   = 3'd2;
    localparam logic [2:0] S_LOOK   = 3'd3;
    localparam logic [2:0] S_SQ     = 3'd4;
    localparam logic [2:0] S_OUT0   = 3'd5;
    localparam logic [2:0] S_OUT1   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_pair2, n_pair2;
    logic       r_second, n_second;
    logic       have_pair;
    logic       pair2;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd     = '0;
        n_state   = r_state;
        n_pair2   = r_pair2;
        n_second  = r_second;
        have_pair = 1'b0;
        pair2     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_status.act)
                    pfc_pkg::ACT_KEY: begin
                        o_cmd.place_key = i_status.key_ok;
                    end
                    pfc_pkg::ACT_FINISH: begin
                        o_cmd.walk_start = 1'b1;
                    end
                    pfc_pkg::ACT_TEXT: begin
                        if (i_status.full) begin
                            if (i_status.decrypt) begin
                                if (i_status.held_v) begin
                                    have_pair       = 1'b1;
                                    o_cmd.pair_kind = pfc_pkg::PAIR_HC;
                                    o_cmd.held_op   = pfc_pkg::HOLD_CLEAR;
                                end else begin
                                    o_cmd.held_op = pfc_pkg::HOLD_LOAD;
                                end
                            end else if (!i_status.held_v) begin
                                if (i_status.prior_v && i_status.c_eq_prior) begin
                                    have_pair       = 1'b1;
                                    o_cmd.pair_kind = pfc_pkg::PAIR_XC;
                                end else begin
                                    o_cmd.held_op = pfc_pkg::HOLD_LOAD;
                                end
                            end else if (i_status.c_eq_held) begin
                                // doubled letter: X closes the pair, X-X starts another
                                have_pair       = 1'b1;
                                pair2           = i_status.c_is_x;
                                o_cmd.pair_kind = pfc_pkg::PAIR_HX;
                                o_cmd.prior_op  = pfc_pkg::PRI_LOAD_X;
                                o_cmd.held_op   = i_status.c_is_x ? pfc_pkg::HOLD_CLEAR
                                                                  : pfc_pkg::HOLD_LOAD;
                            end else begin
                                have_pair       = 1'b1;
                                o_cmd.pair_kind = pfc_pkg::PAIR_HC;
                                o_cmd.held_op   = pfc_pkg::HOLD_CLEAR;
                                o_cmd.prior_op  = pfc_pkg::PRI_LOAD_C;
                            end
                        end
                    end
                    pfc_pkg::ACT_END: begin
                        if (i_status.full) begin
                            o_cmd.held_op  = pfc_pkg::HOLD_CLEAR;
                            o_cmd.prior_op = pfc_pkg::PRI_CLEAR;
                            if (i_status.held_v && !i_status.decrypt) begin
                                have_pair       = 1'b1;
                                o_cmd.pair_kind = pfc_pkg::PAIR_HX;
                            end
                        end
                    end
                endcase
                o_cmd.latch_ops = have_pair;
                n_pair2         = pair2;
                n_second        = 1'b0;
                if (i_status.act == pfc_pkg::ACT_FINISH) begin
                    n_state = S_WALK;
                end else if (have_pair) begin
                    n_state = S_LOOK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_WALK: begin
                o_cmd.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    n_state = S_IDLE;
                end
            end
            S_LOOK: begin
                o_cmd.lookup = 1'b1;
                o_cmd.second = r_second;
                n_state      = S_SQ;
            end
            S_SQ: begin
                o_cmd.square = 1'b1;
                n_state      = S_OUT0;
            end
            S_OUT0: begin
                if (i_status.out_free) begin
                    o_cmd.emit_a = 1'b1;
                    n_state      = S_OUT1;
                end
            end
            S_OUT1: begin
                if (i_status.out_free) begin
                    o_cmd.emit_b = 1'b1;
                    o_cmd.last_b = !r_pair2;
                    if (r_pair2) begin
                        n_pair2  = 1'b0;
                        n_second = 1'b1;
                        n_state  = S_LOOK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pair2  <= 1'b0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pair2  <= n_pair2;
            r_second <= n_second;
        end
    end

    // a square read is always followed by the first output stage
    a_sq_then_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQ) |=> (r_state == S_OUT0))
        else $error("square read not followed by output stage");

    // the second pair never schedules a third
    a_second_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_second |-> !r_pair2)
        else $error("second pair still flagged as pending");

    // a pair is only worked on after the square is complete
    a_pair_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> i_status.full)
        else $error("pair lookup before square complete");

endmodule

// File: src/pfc_datapath.sv
// ----------------------------------------------------------------------------
// Playfair datapath
// Square and letter-place stores, key placement, pairing state, the pair
// transform and the output beat register.
// ----------------------------------------------------------------------------
module pfc_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfc_pkg::t_cmd     i_cmd,
    output pfc_pkg::t_status  o_status,
    input  pfc_pkg::t_in_item i_in_item,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output pfc_pkg::t_out_item o_out_item
);

    // stores: written once per letter, undefined until then
    logic [4:0] r_square [0:24];
    logic [4:0] r_place  [0:25];

    logic [1:0]  r_act;
    logic [7:0]  r_char;
    logic        r_decrypt;
    logic [25:0] r_used;
    logic [4:0]  r_fill;
    logic [4:0]  r_walk;
    logic [4:0]  r_held;
    logic        r_held_v;
    logic [4:0]  r_prior;
    logic        r_prior_v;
    logic [4:0]  r_op_a, r_op_b;
    logic [4:0]  r_pos_a, r_pos_b;
    logic [4:0]  r_let_a, r_let_b;
    logic        r_out_valid;
    pfc_pkg::t_out_item r_out_item;

    pfc_pkg::t_key_letter key;
    logic [4:0] txt;
    logic       full;
    logic       key_ok;
    logic       walk_ok;
    logic       do_place;
    logic [4:0] place_k;
    logic [4:0] look_a, look_b;
    logic [2:0] ra, ca, rb, cb;
    logic [4:0] cell_a, cell_b;

    assign key     = pfc_pkg::key_letter(r_char);
    assign txt     = pfc_pkg::text_letter(r_char);
    assign full    = (r_fill == pfc_pkg::CELLS);
    assign key_ok  = key.ok && !r_used[key.idx] && !full;
    assign walk_ok = (r_walk != pfc_pkg::LETTER_J) && !r_used[r_walk] && !full;
    assign do_place = (i_cmd.place_key && key_ok) || (i_cmd.walk_step && walk_ok);
    assign place_k  = i_cmd.place_key ? key.idx : r_walk;

    assign o_status.act        = r_act;
    assign o_status.key_ok     = key_ok;
    assign o_status.full       = full;
    assign o_status.held_v     = r_held_v;
    assign o_status.prior_v    = r_prior_v;
    assign o_status.c_eq_held  = (txt == r_held);
    assign o_status.c_eq_prior = (txt == r_prior);
    assign o_status.c_is_x     = (txt == pfc_pkg::LETTER_X);
    assign o_status.decrypt    = r_decrypt;
    assign o_status.walk_last  = (r_walk == pfc_pkg::LETTER_Z);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // second pair is always X then the text letter
    assign look_a = i_cmd.second ? pfc_pkg::LETTER_X : r_op_a;
    assign look_b = i_cmd.second ? txt : r_op_b;

    // pair transform on the registered positions
    always_comb begin
        ra = pfc_pkg::row_of(r_pos_a);
        ca = pfc_pkg::col_of(r_pos_a);
        rb = pfc_pkg::row_of(r_pos_b);
        cb = pfc_pkg::col_of(r_pos_b);
        if (ca == cb) begin
            cell_a = pfc_pkg::cell_at(pfc_pkg::step5(ra, r_decrypt), ca);
            cell_b = pfc_pkg::cell_at(pfc_pkg::step5(rb, r_decrypt), cb);
        end else if (ra == rb) begin
            cell_a = pfc_pkg::cell_at(ra, pfc_pkg::step5(ca, r_decrypt));
            cell_b = pfc_pkg::cell_at(rb, pfc_pkg::step5(cb, r_decrypt));
        end else begin
            cell_a = pfc_pkg::cell_at(ra, cb);
            cell_b = pfc_pkg::cell_at(rb, ca);
        end
    end

    // stores and payload registers
    always_ff @(posedge i_clk) begin
        if (do_place) begin
            r_square[r_fill] <= place_k;
            r_place[place_k] <= r_fill;
        end
        if (i_cmd.lookup) begin
            r_pos_a <= r_place[look_a];
            r_pos_b <= r_place[look_b];
        end
        if (i_cmd.square) begin
            r_let_a <= r_square[cell_a];
            r_let_b <= r_square[cell_b];
        end
        if (i_cmd.load_in) begin
            r_act  <= i_in_item.action;
            r_char <= i_in_item.char_code;
        end
        if (i_cmd.latch_ops) begin
            r_op_a <= (i_cmd.pair_kind == pfc_pkg::PAIR_XC) ? pfc_pkg::LETTER_X : r_held;
            r_op_b <= (i_cmd.pair_kind == pfc_pkg::PAIR_HX) ? pfc_pkg::LETTER_X : txt;
        end
        if (i_cmd.walk_start) begin
            r_walk <= '0;
        end else if (i_cmd.walk_step) begin
            r_walk <= r_walk + 5'd1;
        end
        if (i_cmd.emit_a) begin
            r_out_item.letter      <= 7'({3'b000, r_let_a} + pfc_pkg::ASCII_UA);
            r_out_item.last_of_run <= 1'b0;
        end else if (i_cmd.emit_b) begin
            r_out_item.letter      <= 7'({3'b000, r_let_b} + pfc_pkg::ASCII_UA);
            r_out_item.last_of_run <= i_cmd.last_b;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt   <= 1'b0;
            r_used      <= '0;
            r_fill      <= '0;
            r_held      <= '0;
            r_held_v    <= 1'b0;
            r_prior     <= '0;
            r_prior_v   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_decrypt <= i_cfg_data;
            end
            if (do_place) begin
                r_used[place_k] <= 1'b1;
                r_fill          <= r_fill + 5'd1;
            end
            case (i_cmd.held_op)
                pfc_pkg::HOLD_LOAD: begin
                    r_held   <= txt;
                    r_held_v <= 1'b1;
                end
                pfc_pkg::HOLD_CLEAR: begin
                    r_held   <= '0;
                    r_held_v <= 1'b0;
                end
                default: ;
            endcase
            case (i_cmd.prior_op)
                pfc_pkg::PRI_LOAD_C: begin
                    r_prior   <= txt;
                    r_prior_v <= 1'b1;
                end
                pfc_pkg::PRI_LOAD_X: begin
                    r_prior   <= pfc_pkg::LETTER_X;
                    r_prior_v <= 1'b1;
                end
                pfc_pkg::PRI_CLEAR: begin
                    r_prior   <= '0;
                    r_prior_v <= 1'b0;
                end
                default: ;
            endcase
            if (i_cmd.emit_a || i_cmd.emit_b) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // every placed letter is counted exactly once
    a_fill_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == 32'(r_fill))
        else $error("fill count and used letters disagree");

    // pairing state only exists once the square is complete
    a_held_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held_v || r_prior_v) |-> full)
        else $error("pairing state set before square complete");

    // J is never placed
    a_no_j: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_used[pfc_pkg::LETTER_J])
        else $error("J placed in square");

endmodule
